// File: hw/rtl/mips_instruction_execute_top_macros.svh
// Assertion macros shared by the instruction execute block.
`ifndef MIPS_INSTRUCTION_EXECUTE_TOP_MACROS_SVH
`define MIPS_INSTRUCTION_EXECUTE_TOP_MACROS_SVH
`ifndef ASSERT_OFF
`define MIE_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define MIE_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define MIE_ASSERT(label, prop, msg)
`define MIE_ASSERT_ALWAYS(label, prop, msg)
`endif
`endif

// File: hw/rtl/mie_pkg.sv
// Shared types and constants of the instruction execute block.
package mie_pkg;

  localparam int WORD_W     = 32;
  localparam int MUL_W      = 33;
  localparam int CFG_W      = 16;
  localparam int REG_N      = 32;
  localparam int RA_W       = 5;
  localparam int DIV_STEPS  = 32;
  localparam int DIV_CNT_W  = 5;

  localparam logic [RA_W-1:0] REG_SP = 5'd29;
  localparam logic [RA_W-1:0] REG_RA = 5'd31;
  localparam logic [RA_W-1:0] REG_V0 = 5'd2;
  localparam logic [RA_W-1:0] REG_A0 = 5'd4;
  localparam logic [RA_W-1:0] REG_A1 = 5'd5;

  typedef enum logic [5:0] {
    OP_ADD, OP_ADDU, OP_ADDIU, OP_SUB, OP_SUBU, OP_MUL, OP_MULU, OP_MULT,
    OP_MULTU, OP_DIV, OP_DIVU, OP_DIVHL, OP_DIVUHL, OP_XOR, OP_XORU, OP_NEG,
    OP_NEGU, OP_REM, OP_REMU, OP_LI, OP_SEQ, OP_SGE, OP_SGT, OP_SLE,
    OP_SLT, OP_SNE, OP_B, OP_J, OP_BEQ, OP_BNE, OP_BGE, OP_BLE,
    OP_BGT, OP_BLT, OP_BEQZ, OP_BNEZ, OP_BLEZ, OP_BGEZ, OP_BGTZ, OP_BLTZ,
    OP_JR, OP_JAL, OP_JALR, OP_LA, OP_LB, OP_LH, OP_LW, OP_SB,
    OP_SH, OP_SW, OP_MOVE, OP_MFHI, OP_MFLO, OP_SYSCALL
  } op_t;

  typedef enum logic [2:0] {CL_ALU, CL_MUL, CL_DIV, CL_LOAD, CL_STORE, CL_SYS} fclass_t;
  typedef enum logic [2:0] {RD_S, RD_T, RD_F, RD_V0, RD_A0, RD_A1} rd_sel_t;
  typedef enum logic [2:0] {CAP_NONE, CAP_A, CAP_T, CAP_X, CAP_SN, CAP_A0, CAP_A1} cap_t;
  typedef enum logic {DSRC_OPS, DSRC_ADDR} div_src_t;

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_RS, S_RT, S_RF, S_DISP, S_MUL, S_DSTART, S_DIV,
    S_ASTART, S_ADIV, S_AADR, S_MRD, S_MCAP, S_MWR, S_SY2, S_SY4, S_SY5,
    S_SYC, S_WB
  } state_t;

  typedef struct packed {
    logic     take_in;
    rd_sel_t  rd_sel;
    cap_t     cap;
    logic     div_start;
    div_src_t div_src;
    logic     div_step;
    logic     mul;
    logic     mem_clear;
    logic     addr_load;
    logic     mem_wr;
    logic     mem_cap;
    logic     wb;
  } dp_cmd_t;

  typedef struct packed {
    fclass_t fclass;
    logic    div_last;
    logic    clear_last;
    logic    byte_last;
    logic    out_free;
  } dp_sts_t;

endpackage

// File: hw/rtl/mie_div.sv
// Restoring divider for unsigned 32-bit magnitudes, one quotient bit per cycle while step is high.
module mie_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic        step,
  input  logic [31:0] dividend,
  input  logic [31:0] divisor,
  output logic [31:0] quot,
  output logic [31:0] rem,
  output logic        last
);
  import mie_pkg::*;

  logic [WORD_W-1:0]    dq;
  logic [WORD_W-1:0]    rm;
  logic [WORD_W-1:0]    dvs;
  logic [DIV_CNT_W-1:0] cnt;
  logic [WORD_W:0]      trial;
  logic                 ge;

  assign trial = {rm, dq[WORD_W-1]} - {1'b0, dvs};
  assign ge    = !trial[WORD_W];

  always_ff @(posedge clk) begin
    if (start) begin
      dq  <= dividend;
      rm  <= '0;
      dvs <= divisor;
    end else if (step) begin
      rm  <= ge ? trial[WORD_W-1:0] : {rm[WORD_W-2:0], dq[WORD_W-1]};
      dq  <= {dq[WORD_W-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (start) begin
      cnt <= '0;
    end else if (step) begin
      cnt <= cnt + 1'b1;
    end
  end

  assign last = (cnt == DIV_CNT_W'(DIV_STEPS - 1));
  assign quot = dq;
  assign rem  = rm;
endmodule

// File: hw/rtl/mie_dp.sv
// Datapath: register file, HI/LO, program index, data memory, multiplier and divider.
module mie_dp #(
  parameter int MEM_BYTES  = 65536,
  parameter int INDEX_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  mie_pkg::dp_cmd_t      cmd,
  output mie_pkg::dp_sts_t      sts,
  input  logic [5:0]            func,
  input  logic [4:0]            first_reg,
  input  logic [4:0]            second_reg,
  input  logic [4:0]            third_reg,
  input  logic                  use_immediate,
  input  logic signed [31:0]    immediate,
  input  logic                  absolute_address,
  input  logic [INDEX_BITS-1:0] jump_target,
  input  logic                  cfg_we,
  input  logic [15:0]           cfg_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [INDEX_BITS-1:0] next_index,
  output logic                  syscall_request,
  output logic signed [31:0]    service_number,
  output logic signed [31:0]    argument_zero,
  output logic signed [31:0]    argument_one
);
  import mie_pkg::*;

  localparam int AW = $clog2(MEM_BYTES);

  // Latched instruction.
  logic [5:0]            func_q;
  logic [RA_W-1:0]       f_q, s_q, t_q;
  logic                  ui_q, absa_q;
  logic [WORD_W-1:0]     imm_q;
  logic [INDEX_BITS-1:0] tgt_q;

  always_ff @(posedge clk) begin
    if (cmd.take_in) begin
      func_q <= func;
      f_q    <= first_reg;
      s_q    <= second_reg;
      t_q    <= third_reg;
      ui_q   <= use_immediate;
      imm_q  <= immediate;
      absa_q <= absolute_address;
      tgt_q  <= jump_target;
    end
  end

  // Register file with valid bits standing in for the reset values.
  logic [WORD_W-1:0] rf [REG_N];
  logic [REG_N-1:0]  rf_vld;
  logic [RA_W-1:0]   ra;
  logic [WORD_W-1:0] rf_q;
  logic              rf_we;
  logic [RA_W-1:0]   rf_wa;
  logic [WORD_W-1:0] rf_wd;

  always_comb begin
    case (cmd.rd_sel)
      RD_S:    ra = s_q;
      RD_T:    ra = t_q;
      RD_F:    ra = f_q;
      RD_V0:   ra = REG_V0;
      RD_A0:   ra = REG_A0;
      RD_A1:   ra = REG_A1;
      default: ra = s_q;
    endcase
  end

  always_ff @(posedge clk) begin
    if (ra == '0) begin
      rf_q <= '0;
    end else if (rf_vld[ra]) begin
      rf_q <= rf[ra];
    end else if (ra == REG_SP) begin
      rf_q <= WORD_W'(MEM_BYTES);
    end else begin
      rf_q <= '0;
    end
    if (rf_we && rf_wa != '0) begin
      rf[rf_wa] <= rf_wd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rf_vld <= '0;
    end else if (rf_we && rf_wa != '0) begin
      rf_vld[rf_wa] <= 1'b1;
    end
  end

  // Operand registers.
  logic [WORD_W-1:0] a_r, t_r, x_r, sn_r, a0_r, a1_r;

  always_ff @(posedge clk) begin
    case (cmd.cap)
      CAP_A:   a_r  <= rf_q;
      CAP_T:   t_r  <= rf_q;
      CAP_X:   x_r  <= rf_q;
      CAP_SN:  sn_r <= rf_q;
      CAP_A0:  a0_r <= rf_q;
      CAP_A1:  a1_r <= rf_q;
      default: ;
    endcase
  end

  logic [WORD_W-1:0] src3, src2, addr;
  assign src3 = ui_q ? imm_q : t_r;
  assign src2 = ui_q ? imm_q : a_r;
  assign addr = absa_q ? imm_q : a_r + imm_q;

  always_comb begin
    case (func_q)
      OP_MUL, OP_MULU, OP_MULT, OP_MULTU:               sts.fclass = CL_MUL;
      OP_DIV, OP_DIVU, OP_DIVHL, OP_DIVUHL, OP_REM, OP_REMU: sts.fclass = CL_DIV;
      OP_LB, OP_LH, OP_LW:                              sts.fclass = CL_LOAD;
      OP_SB, OP_SH, OP_SW:                              sts.fclass = CL_STORE;
      OP_SYSCALL:                                       sts.fclass = CL_SYS;
      default:                                          sts.fclass = CL_ALU;
    endcase
  end

  // Multiplier: 33-bit operands cover both the signed and the unsigned wide forms.
  logic signed [MUL_W-1:0]   m1, m2;
  logic signed [2*MUL_W-1:0] pfull;
  logic [2*WORD_W-1:0]       prod;

  always_comb begin
    case (func_q)
      OP_MULT: begin
        m1 = {x_r[WORD_W-1], x_r};
        m2 = {src2[WORD_W-1], src2};
      end
      OP_MULTU: begin
        m1 = {1'b0, x_r};
        m2 = {1'b0, src2};
      end
      default: begin
        m1 = {1'b0, a_r};
        m2 = {1'b0, src3};
      end
    endcase
  end

  assign pfull = m1 * m2;

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      prod <= pfull[2*WORD_W-1:0];
    end
  end

  // Divider operands.
  logic [WORD_W-1:0] dn, dd, dn_mag, dd_mag, n_r, quot, rem, q_fix, r_fix;
  logic              dsig, sn_neg, sd_neg, sn_q, sd_q, dz_q;

  always_comb begin
    dn   = a_r;
    dd   = src3;
    dsig = 1'b0;
    case (func_q)
      OP_DIVHL: begin
        dn   = x_r;
        dd   = src2;
        dsig = 1'b1;
      end
      OP_DIVUHL: begin
        dn = x_r;
        dd = src2;
      end
      OP_DIV, OP_REM: dsig = 1'b1;
      default: ;
    endcase
  end

  assign sn_neg = dsig & dn[WORD_W-1];
  assign sd_neg = dsig & dd[WORD_W-1];
  assign dn_mag = sn_neg ? -dn : dn;
  assign dd_mag = sd_neg ? -dd : dd;

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      n_r  <= dn;
      sn_q <= sn_neg;
      sd_q <= sd_neg;
      dz_q <= (dd == '0);
    end
  end

  mie_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .step     (cmd.div_step),
    .dividend (dn_mag),
    .divisor  (dd_mag),
    .quot     (quot),
    .rem      (rem),
    .last     (sts.div_last)
  );

  // A zero divisor gives all ones and leaves the dividend as remainder.
  assign q_fix = dz_q ? '1 : ((sn_q ^ sd_q) ? -quot : quot);
  assign r_fix = dz_q ? n_r : (sn_q ? -rem : rem);

  // Address reduction modulo the memory size by reciprocal multiplication. The quotient
  // estimate is at most one low, so a single conditional subtract completes the remainder.
  localparam logic [WORD_W-1:0] MEM_W      = WORD_W'(MEM_BYTES);
  localparam logic [WORD_W-1:0] ADDR_RECIP = WORD_W'((64'd1 << WORD_W) / MEM_BYTES);

  logic [2*WORD_W-1:0] aq_full;
  logic [WORD_W-1:0]   aq, aback, ar, amod;

  assign aq_full = addr * ADDR_RECIP;
  assign aback   = aq * MEM_W;
  assign amod    = (ar >= MEM_W) ? ar - MEM_W : ar;

  always_ff @(posedge clk) begin
    if (cmd.div_src == DSRC_ADDR) begin
      aq <= aq_full[2*WORD_W-1:WORD_W];
      ar <= addr - aback;
    end
  end

  // Byte data memory, one byte per access. maddr also walks the clearing pass.
  logic [7:0]        dmem [MEM_BYTES];
  logic [AW-1:0]     maddr;
  logic [AW-1:0]     maddr_inc;
  logic [1:0]        k;
  logic [1:0]        last_k;
  logic [7:0]        mem_rdata;
  logic [7:0]        st_byte;
  logic [WORD_W-1:0] ld;
  logic              mem_we;

  assign maddr_inc = (maddr == AW'(MEM_BYTES - 1)) ? '0 : maddr + 1'b1;
  assign mem_we    = cmd.mem_clear | cmd.mem_wr;
  assign st_byte   = cmd.mem_clear ? 8'h00 : 8'(x_r >> {k, 3'b000});

  always_ff @(posedge clk) begin
    if (mem_we) begin
      dmem[maddr] <= st_byte;
    end
    mem_rdata <= dmem[maddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      maddr <= '0;
      k     <= '0;
    end else if (cmd.addr_load) begin
      maddr <= amod[AW-1:0];
      k     <= '0;
    end else if (cmd.mem_clear || cmd.mem_wr || cmd.mem_cap) begin
      maddr <= maddr_inc;
      k     <= k + 1'b1;
    end
  end

  // Loaded bytes shift in from the top, so a short load ends in the high bits.
  always_ff @(posedge clk) begin
    if (cmd.mem_cap) begin
      ld <= {mem_rdata, ld[WORD_W-1:8]};
    end
  end

  always_comb begin
    case (func_q)
      OP_LB, OP_SB: last_k = 2'd0;
      OP_LH, OP_SH: last_k = 2'd1;
      default:      last_k = 2'd3;
    endcase
  end

  assign sts.byte_last  = (k == last_k);
  assign sts.clear_last = (maddr == AW'(MEM_BYTES - 1));

  // Architectural HI, LO and program index.
  logic [WORD_W-1:0]     hi, lo, hi_next, lo_next;
  logic                  hilo_we;
  logic [INDEX_BITS-1:0] pc, pc_inc, nxt;
  logic [WORD_W-1:0]     cfg_wide, link;
  logic                  take, jreg, sys;
  logic                  lt_as, lt_sa, lt_xs, lt_sx;

  assign pc_inc   = pc + 1'b1;
  assign link     = WORD_W'(pc) + 1'b1;
  assign cfg_wide = WORD_W'(cfg_data);
  assign lt_as    = $signed(a_r) < $signed(src3);
  assign lt_sa    = $signed(src3) < $signed(a_r);
  assign lt_xs    = $signed(x_r) < $signed(src2);
  assign lt_sx    = $signed(src2) < $signed(x_r);

  always_comb begin
    rf_we   = 1'b0;
    rf_wa   = f_q;
    rf_wd   = '0;
    hilo_we = 1'b0;
    hi_next = hi;
    lo_next = lo;
    take    = 1'b0;
    jreg    = 1'b0;
    sys     = 1'b0;
    case (func_q)
      OP_ADD, OP_ADDU: begin rf_we = 1'b1; rf_wd = a_r + src3; end
      OP_ADDIU:        begin rf_we = 1'b1; rf_wd = a_r + imm_q; end
      OP_SUB, OP_SUBU: begin rf_we = 1'b1; rf_wd = a_r - src3; end
      OP_MUL, OP_MULU: begin rf_we = 1'b1; rf_wd = prod[WORD_W-1:0]; end
      OP_MULT, OP_MULTU: begin
        hilo_we = 1'b1;
        hi_next = prod[2*WORD_W-1:WORD_W];
        lo_next = prod[WORD_W-1:0];
      end
      OP_DIV, OP_DIVU: begin rf_we = 1'b1; rf_wd = q_fix; end
      OP_REM, OP_REMU: begin rf_we = 1'b1; rf_wd = r_fix; end
      OP_DIVHL, OP_DIVUHL: begin
        hilo_we = 1'b1;
        hi_next = r_fix;
        lo_next = q_fix;
      end
      OP_XOR, OP_XORU: begin rf_we = 1'b1; rf_wd = a_r ^ src3; end
      OP_NEG, OP_NEGU: begin rf_we = 1'b1; rf_wd = -a_r; end
      OP_LI:   begin rf_we = 1'b1; rf_wd = imm_q; end
      OP_SEQ:  begin rf_we = 1'b1; rf_wd = WORD_W'(a_r == src3); end
      OP_SGE:  begin rf_we = 1'b1; rf_wd = WORD_W'(!lt_as); end
      OP_SGT:  begin rf_we = 1'b1; rf_wd = WORD_W'(lt_sa); end
      OP_SLE:  begin rf_we = 1'b1; rf_wd = WORD_W'(!lt_sa); end
      OP_SLT:  begin rf_we = 1'b1; rf_wd = WORD_W'(lt_as); end
      OP_SNE:  begin rf_we = 1'b1; rf_wd = WORD_W'(a_r != src3); end
      OP_B, OP_J: take = 1'b1;
      OP_BEQ:  take = (x_r == src2);
      OP_BNE:  take = (x_r != src2);
      OP_BGE:  take = !lt_xs;
      OP_BLE:  take = !lt_sx;
      OP_BGT:  take = lt_sx;
      OP_BLT:  take = lt_xs;
      OP_BEQZ: take = (x_r == '0);
      OP_BNEZ: take = (x_r != '0);
      OP_BLEZ: take = x_r[WORD_W-1] || (x_r == '0);
      OP_BGEZ: take = !x_r[WORD_W-1];
      OP_BGTZ: take = !x_r[WORD_W-1] && (x_r != '0);
      OP_BLTZ: take = x_r[WORD_W-1];
      OP_JR:   jreg = 1'b1;
      OP_JAL: begin
        rf_we = 1'b1; rf_wa = REG_RA; rf_wd = link; take = 1'b1;
      end
      OP_JALR: begin
        rf_we = 1'b1; rf_wa = REG_RA; rf_wd = link; jreg = 1'b1;
      end
      OP_LA:   begin rf_we = 1'b1; rf_wd = addr; end
      OP_LB:   begin rf_we = 1'b1; rf_wd = {{24{ld[31]}}, ld[31:24]}; end
      OP_LH:   begin rf_we = 1'b1; rf_wd = {{16{ld[31]}}, ld[31:16]}; end
      OP_LW:   begin rf_we = 1'b1; rf_wd = ld; end
      OP_MOVE: begin rf_we = 1'b1; rf_wd = a_r; end
      OP_MFHI: begin rf_we = 1'b1; rf_wd = hi; end
      OP_MFLO: begin rf_we = 1'b1; rf_wd = lo; end
      OP_SYSCALL: sys = 1'b1;
      default: ;
    endcase
    rf_we = rf_we & cmd.wb;
    if (take) begin
      nxt = tgt_q;
    end else if (jreg) begin
      nxt = x_r[INDEX_BITS-1:0];
    end else begin
      nxt = pc_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hi <= '0;
      lo <= '0;
      pc <= '0;
    end else begin
      if (cmd.wb && hilo_we) begin
        hi <= hi_next;
        lo <= lo_next;
      end
      if (cfg_we) begin
        pc <= cfg_wide[INDEX_BITS-1:0];
      end else if (cmd.wb) begin
        pc <= nxt;
      end
    end
  end

  // Output register: holds a finished beat until the consumer takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.wb) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wb) begin
      next_index      <= nxt;
      syscall_request <= sys;
      service_number  <= sys ? sn_r : '0;
      argument_zero   <= sys ? a0_r : '0;
      argument_one    <= sys ? a1_r : '0;
    end
  end

  assign sts.out_free = !out_valid || !out_stall;
endmodule

// File: hw/rtl/mie_ctrl.sv
// Controller state machine that sequences each instruction through the datapath.
`include "mips_instruction_execute_top_macros.svh"
module mie_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  output mie_pkg::dp_cmd_t cmd,
  input  mie_pkg::dp_sts_t sts
);
  import mie_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd        = '0;
    cmd.rd_sel = RD_S;
    cmd.cap    = CAP_NONE;
    cmd.div_src = DSRC_OPS;
    state_next = state;
    in_stall   = 1'b1;
    case (state)
      S_CLEAR: begin
        cmd.mem_clear = 1'b1;
        if (sts.clear_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        in_stall    = 1'b0;
        cmd.take_in = in_valid;
        if (in_valid) state_next = S_RS;
      end
      S_RS: begin
        cmd.rd_sel = RD_S;
        state_next = S_RT;
      end
      S_RT: begin
        cmd.rd_sel = RD_T;
        cmd.cap    = CAP_A;
        state_next = S_RF;
      end
      S_RF: begin
        cmd.rd_sel = RD_F;
        cmd.cap    = CAP_T;
        state_next = S_DISP;
      end
      S_DISP: begin
        cmd.cap = CAP_X;
        case (sts.fclass)
          CL_MUL:             state_next = S_MUL;
          CL_DIV:             state_next = S_DSTART;
          CL_LOAD, CL_STORE:  state_next = S_ASTART;
          CL_SYS:             state_next = S_SY2;
          default:            state_next = S_WB;
        endcase
      end
      S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = S_WB;
      end
      S_DSTART: begin
        cmd.div_start = 1'b1;
        state_next    = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) state_next = S_WB;
      end
      // Address reduction in S_ASTART and S_ADIV: quotient estimate, then the partial remainder.
      S_ASTART: begin
        cmd.div_src = DSRC_ADDR;
        state_next  = S_ADIV;
      end
      S_ADIV: begin
        cmd.div_src = DSRC_ADDR;
        state_next  = S_AADR;
      end
      S_AADR: begin
        cmd.addr_load = 1'b1;
        state_next    = (sts.fclass == CL_LOAD) ? S_MRD : S_MWR;
      end
      S_MRD: state_next = S_MCAP;
      S_MCAP: begin
        cmd.mem_cap = 1'b1;
        state_next  = sts.byte_last ? S_WB : S_MRD;
      end
      S_MWR: begin
        cmd.mem_wr = 1'b1;
        if (sts.byte_last) state_next = S_WB;
      end
      S_SY2: begin
        cmd.rd_sel = RD_V0;
        state_next = S_SY4;
      end
      S_SY4: begin
        cmd.rd_sel = RD_A0;
        cmd.cap    = CAP_SN;
        state_next = S_SY5;
      end
      S_SY5: begin
        cmd.rd_sel = RD_A1;
        cmd.cap    = CAP_A0;
        state_next = S_SYC;
      end
      S_SYC: begin
        cmd.cap    = CAP_A1;
        state_next = S_WB;
      end
      S_WB: begin
        if (sts.out_free) begin
          cmd.wb     = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  `MIE_ASSERT(a_accept_starts_read, (in_valid && !in_stall) |=> (state == S_RS), "accepted beat did not start operand reads")
  `MIE_ASSERT(a_wb_needs_room, cmd.wb |-> sts.out_free, "writeback while output register is full")
  `MIE_ASSERT(a_step_in_div, cmd.div_step |-> (state == S_DIV), "divider stepped outside a divide")
  `MIE_ASSERT_ALWAYS(a_clear_stalls, (state == S_CLEAR) |-> in_stall, "input taken during memory clearing")
endmodule

// File: hw/rtl/mips_instruction_execute_top.sv
// Top level of the instruction execute block: one decoded instruction in, one result beat out.
// Executes one decoded MIPS32-style integer instruction per input beat and returns the next
// instruction index, plus registers 2, 4 and 5 for a system call. Register, ALU, set, branch
// and jump instructions pass through three register reads and a dispatch state; multiplies add
// a multiply state; divides and remainders step the one-bit-per-cycle divider and are the
// slowest item. Loads and stores reduce the address modulo MEM_BYTES (S_ASTART, S_ADIV and
// S_AADR); stores then write one byte per cycle, while loads read and capture each byte in turn
// (S_MRD, then S_MCAP). One instruction is in flight at a time, and the block returns to idle
// after each writeback before it accepts the next beat, which it does even while a finished
// result still waits in the output register; the following result then waits in writeback
// until that beat is taken. After reset the data memory is cleared one byte per cycle, so no
// input beat is accepted until all MEM_BYTES bytes (65536 by default) are cleared;
// configuration writes are taken at any time and load the program index from cfg_data.
module mips_instruction_execute_top #(
  parameter int MEM_BYTES  = 65536,
  parameter int INDEX_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [5:0]            func,
  input  logic [4:0]            first_reg,
  input  logic [4:0]            second_reg,
  input  logic [4:0]            third_reg,
  input  logic                  use_immediate,
  input  logic signed [31:0]    immediate,
  input  logic                  absolute_address,
  input  logic [INDEX_BITS-1:0] jump_target,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [INDEX_BITS-1:0] next_index,
  output logic                  syscall_request,
  output logic signed [31:0]    service_number,
  output logic signed [31:0]    argument_zero,
  output logic signed [31:0]    argument_one,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [15:0]           cfg_data
);
  import mie_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;
  logic    cfg_we;

  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;

  mie_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .cmd      (cmd),
    .sts      (sts)
  );

  mie_dp #(
    .MEM_BYTES  (MEM_BYTES),
    .INDEX_BITS (INDEX_BITS)
  ) u_dp (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .sts              (sts),
    .func             (func),
    .first_reg        (first_reg),
    .second_reg       (second_reg),
    .third_reg        (third_reg),
    .use_immediate    (use_immediate),
    .immediate        (immediate),
    .absolute_address (absolute_address),
    .jump_target      (jump_target),
    .cfg_we           (cfg_we),
    .cfg_data         (cfg_data),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .next_index       (next_index),
    .syscall_request  (syscall_request),
    .service_number   (service_number),
    .argument_zero    (argument_zero),
    .argument_one     (argument_one)
  );
endmodule

// File: tb/testbench.sv
// Self-checking testbench of the instruction execute block with an in-house instruction predictor.
`timescale 1ns / 100ps

module testbench;
  import mie_pkg::*;

  typedef struct packed {
    logic [5:0]  func;
    logic [4:0]  first_reg;
    logic [4:0]  second_reg;
    logic [4:0]  third_reg;
    logic        use_immediate;
    logic [31:0] immediate;
    logic        absolute_address;
    logic [15:0] jump_target;
  } instr_t;

  typedef struct packed {
    logic [15:0] next_index;
    logic        syscall_request;
    logic [31:0] service_number;
    logic [31:0] argument_zero;
    logic [31:0] argument_one;
  } outcome_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [5:0] func = '0;
  logic [4:0] first_reg = '0;
  logic [4:0] second_reg = '0;
  logic [4:0] third_reg = '0;
  logic use_immediate = 1'b0;
  logic signed [31:0] immediate = '0;
  logic absolute_address = 1'b0;
  logic [15:0] jump_target = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [15:0] next_index;
  logic syscall_request;
  logic signed [31:0] service_number;
  logic signed [31:0] argument_zero;
  logic signed [31:0] argument_one;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [15:0] cfg_data = '0;

  mips_instruction_execute_top u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .func(func), .first_reg(first_reg), .second_reg(second_reg), .third_reg(third_reg),
    .use_immediate(use_immediate), .immediate(immediate),
    .absolute_address(absolute_address), .jump_target(jump_target),
    .out_valid(out_valid), .out_stall(out_stall),
    .next_index(next_index), .syscall_request(syscall_request),
    .service_number(service_number), .argument_zero(argument_zero),
    .argument_one(argument_one),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  // Shadow architectural state.
  logic [31:0] gpr [32];
  logic [31:0] hi_word, lo_word;
  logic [15:0] pc;
  logic [7:0]  dmem [65536];

  instr_t   pending_instrs[$];
  outcome_t expected_outcomes[$];
  int       errors = 0;
  int       results_seen = 0;
  int       send_idle_pct = 0;
  int       recv_idle_pct = 0;
  int       hold_cycles = 0;
  bit       hold_done = 1'b0;

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    #4000000;
    $display("RESULT: ERROR");
    $finish;
  end

  function automatic logic [31:0] rreg(logic [4:0] n);
    return (n == 0) ? 32'd0 : gpr[n];
  endfunction

  function automatic logic signed_lt(logic [31:0] a, logic [31:0] b);
    return $signed(a) < $signed(b);
  endfunction

  task automatic wreg(logic [4:0] n, logic [31:0] v);
    if (n != 0) gpr[n] = v;
  endtask

  task automatic div_signed(input logic [31:0] a, input logic [31:0] b,
                            output logic [31:0] q, output logic [31:0] r);
    logic [31:0] ma, mb;
    if (b == 0) begin
      q = '1;
      r = a;
    end else begin
      ma = a[31] ? -a : a;
      mb = b[31] ? -b : b;
      q = (a[31] ^ b[31]) ? -(ma / mb) : ma / mb;
      r = a[31] ? -(ma % mb) : ma % mb;
    end
  endtask

  task automatic div_unsigned(input logic [31:0] a, input logic [31:0] b,
                              output logic [31:0] q, output logic [31:0] r);
    if (b == 0) begin
      q = '1;
      r = a;
    end else begin
      q = a / b;
      r = a % b;
    end
  endtask

  function automatic logic [31:0] mem_read(logic [31:0] addr, int n);
    logic [31:0] v;
    logic [15:0] base;
    v = 0;
    base = addr[15:0];
    for (int k = 0; k < n; k++) v |= 32'(dmem[16'(base + k)]) << (8 * k);
    return v;
  endfunction

  task automatic mem_write(logic [31:0] addr, int n, logic [31:0] v);
    logic [15:0] base;
    base = addr[15:0];
    for (int k = 0; k < n; k++) dmem[16'(base + k)] = v[8*k +: 8];
  endtask

  task automatic execute_instr(input instr_t it, output outcome_t res);
    logic [31:0] a, x, src2, src3, addr, q, r, imm;
    logic [63:0] p;
    logic [15:0] nxt;
    logic take, sys;
    imm = it.immediate;
    a = rreg(it.second_reg);
    x = rreg(it.first_reg);
    src3 = it.use_immediate ? imm : rreg(it.third_reg);
    src2 = it.use_immediate ? imm : a;
    addr = it.absolute_address ? imm : a + imm;
    nxt = pc + 16'd1;
    take = 1'b0;
    sys = 1'b0;
    case (it.func)
      OP_ADD, OP_ADDU: wreg(it.first_reg, a + src3);
      OP_ADDIU: wreg(it.first_reg, a + imm);
      OP_SUB, OP_SUBU: wreg(it.first_reg, a - src3);
      OP_MUL, OP_MULU: wreg(it.first_reg, a * src3);
      OP_MULT: begin
        p = {{32{x[31]}}, x} * {{32{src2[31]}}, src2};
        {hi_word, lo_word} = p;
      end
      OP_MULTU: begin
        p = {32'd0, x} * {32'd0, src2};
        {hi_word, lo_word} = p;
      end
      OP_DIV: begin div_signed(a, src3, q, r); wreg(it.first_reg, q); end
      OP_DIVU: begin div_unsigned(a, src3, q, r); wreg(it.first_reg, q); end
      OP_DIVHL: begin div_signed(x, src2, q, r); hi_word = r; lo_word = q; end
      OP_DIVUHL: begin div_unsigned(x, src2, q, r); hi_word = r; lo_word = q; end
      OP_XOR, OP_XORU: wreg(it.first_reg, a ^ src3);
      OP_NEG, OP_NEGU: wreg(it.first_reg, -a);
      OP_REM: begin div_signed(a, src3, q, r); wreg(it.first_reg, r); end
      OP_REMU: begin div_unsigned(a, src3, q, r); wreg(it.first_reg, r); end
      OP_LI: wreg(it.first_reg, imm);
      OP_SEQ: wreg(it.first_reg, 32'(a == src3));
      OP_SGE: wreg(it.first_reg, 32'(!signed_lt(a, src3)));
      OP_SGT: wreg(it.first_reg, 32'(signed_lt(src3, a)));
      OP_SLE: wreg(it.first_reg, 32'(!signed_lt(src3, a)));
      OP_SLT: wreg(it.first_reg, 32'(signed_lt(a, src3)));
      OP_SNE: wreg(it.first_reg, 32'(a != src3));
      OP_B, OP_J: take = 1'b1;
      OP_BEQ: take = x == src2;
      OP_BNE: take = x != src2;
      OP_BGE: take = !signed_lt(x, src2);
      OP_BLE: take = !signed_lt(src2, x);
      OP_BGT: take = signed_lt(src2, x);
      OP_BLT: take = signed_lt(x, src2);
      OP_BEQZ: take = x == 0;
      OP_BNEZ: take = x != 0;
      OP_BLEZ: take = !signed_lt(0, x);
      OP_BGEZ: take = !signed_lt(x, 0);
      OP_BGTZ: take = signed_lt(0, x);
      OP_BLTZ: take = signed_lt(x, 0);
      OP_JR: nxt = x[15:0];
      OP_JAL: begin wreg(REG_RA, 32'(pc) + 32'd1); take = 1'b1; end
      OP_JALR: begin wreg(REG_RA, 32'(pc) + 32'd1); nxt = x[15:0]; end
      OP_LA: wreg(it.first_reg, addr);
      OP_LB: begin r = mem_read(addr, 1); wreg(it.first_reg, {{24{r[7]}}, r[7:0]}); end
      OP_LH: begin r = mem_read(addr, 2); wreg(it.first_reg, {{16{r[15]}}, r[15:0]}); end
      OP_LW: wreg(it.first_reg, mem_read(addr, 4));
      OP_SB: mem_write(addr, 1, x);
      OP_SH: mem_write(addr, 2, x);
      OP_SW: mem_write(addr, 4, x);
      OP_MOVE: wreg(it.first_reg, a);
      OP_MFHI: wreg(it.first_reg, hi_word);
      OP_MFLO: wreg(it.first_reg, lo_word);
      OP_SYSCALL: sys = 1'b1;
      default: ;
    endcase
    if (take) nxt = it.jump_target;
    pc = nxt;
    res.next_index = nxt;
    res.syscall_request = sys;
    res.service_number = sys ? gpr[REG_V0] : 32'd0;
    res.argument_zero = sys ? gpr[REG_A0] : 32'd0;
    res.argument_one = sys ? gpr[REG_A1] : 32'd0;
  endtask

  task automatic queue_instr(instr_t it);
    pending_instrs = {pending_instrs, it};
  endtask

  // Driver: predicts each accepted beat, then offers the next pending instruction.
  always @(posedge clk) begin
    outcome_t res;
    instr_t it;
    if (in_valid && !in_stall) begin
      execute_instr({func, first_reg, second_reg, third_reg, use_immediate, immediate,
                     absolute_address, jump_target}, res);
      expected_outcomes = {expected_outcomes, res};
    end
    if (!rst && (!in_valid || !in_stall)) begin
      if (pending_instrs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        it = pending_instrs.pop_front();
        {func, first_reg, second_reg, third_reg, use_immediate, immediate,
         absolute_address, jump_target} <= it;
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // One long hold-off late in the run lets the block back up into its input.
  always @(posedge clk) begin
    if (!hold_done && results_seen >= 1500) begin
      hold_done <= 1'b1;
      hold_cycles <= 400;
    end else if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
    end
  end

  // Monitor: checks each result beat against the oldest prediction.
  always @(posedge clk) begin
    outcome_t e;
    if (out_valid && !out_stall) begin
      results_seen++;
      if (expected_outcomes.size() == 0) begin
        $error("result beat with no prediction pending");
        errors++;
      end else begin
        e = expected_outcomes.pop_front();
        if (next_index !== e.next_index) begin
          $error("next_index expected %0d actual %0d", e.next_index, next_index);
          errors++;
        end
        if (syscall_request !== e.syscall_request) begin
          $error("syscall_request expected %0d actual %0d", e.syscall_request, syscall_request);
          errors++;
        end
        if (service_number !== e.service_number) begin
          $error("service_number expected %h actual %h", e.service_number, service_number);
          errors++;
        end
        if (argument_zero !== e.argument_zero) begin
          $error("argument_zero expected %h actual %h", e.argument_zero, argument_zero);
          errors++;
        end
        if (argument_one !== e.argument_one) begin
          $error("argument_one expected %h actual %h", e.argument_one, argument_one);
          errors++;
        end
      end
    end
    out_stall <= (hold_cycles > 0) || ($urandom_range(99) < recv_idle_pct);
  end

  function automatic instr_t mk(op_t op, int f, int s, int t, bit ui, logic [31:0] imm,
                                bit absa, logic [15:0] tgt);
    instr_t it;
    it.func = op;
    it.first_reg = 5'(f);
    it.second_reg = 5'(s);
    it.third_reg = 5'(t);
    it.use_immediate = ui;
    it.immediate = imm;
    it.absolute_address = absa;
    it.jump_target = tgt;
    return it;
  endfunction

  function automatic logic [4:0] pick_reg();
    return ($urandom_range(9) < 8) ? 5'($urandom_range(7)) : 5'($urandom_range(31));
  endfunction

  function automatic instr_t random_instr();
    instr_t it;
    it.func = ($urandom_range(19) == 0) ? 6'($urandom_range(63, 54)) : 6'($urandom_range(53));
    it.first_reg = pick_reg();
    it.second_reg = pick_reg();
    it.third_reg = pick_reg();
    it.use_immediate = $urandom_range(1);
    case ($urandom_range(3))
      0: it.immediate = $urandom;
      1: it.immediate = 32'($signed($urandom_range(16)) - 8);
      2: it.immediate = ($urandom_range(1) ? 32'h8000_0000 : 32'h7fff_ffff)
                        + 32'($urandom_range(1));
      default: it.immediate = 32'(65536 - $urandom_range(8)) + ($urandom_range(1) << 31);
    endcase
    it.absolute_address = $urandom_range(1);
    it.jump_target = $urandom;
    return it;
  endfunction

  task automatic write_entry(logic [15:0] v);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    forever begin
      @(posedge clk);
      if (cfg_ready) break;
    end
    pc = v;
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (pending_instrs.size() > 0 || in_valid || expected_outcomes.size() > 0)
      @(posedge clk);
  endtask

  task automatic set_idling(int snd, int rcv);
    @(negedge clk);
    send_idle_pct = snd;
    recv_idle_pct = rcv;
  endtask

  initial begin
    for (int i = 0; i < 32; i++) gpr[i] = 0;
    gpr[REG_SP] = 32'd65536;
    hi_word = 0;
    lo_word = 0;
    pc = 0;
    for (int i = 0; i < 65536; i++) dmem[i] = 0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    write_entry(16'hffff);
    set_idling(26, 52);

    queue_instr(mk(OP_LI, 1, 0, 0, 1, 32'h7fff_ffff, 0, 0));
    queue_instr(mk(OP_LI, 2, 0, 0, 1, 32'h8000_0000, 0, 0));
    queue_instr(mk(OP_LI, 3, 0, 0, 1, 32'hffff_ffff, 0, 0));
    queue_instr(mk(OP_ADD, 4, 1, 0, 1, 32'd1, 0, 0));
    queue_instr(mk(OP_DIV, 5, 2, 3, 0, 0, 0, 0));
    queue_instr(mk(OP_REM, 6, 2, 3, 0, 0, 0, 0));
    queue_instr(mk(OP_DIVU, 7, 1, 0, 0, 0, 0, 0));
    queue_instr(mk(OP_DIVHL, 2, 0, 0, 0, 0, 0, 0));
    queue_instr(mk(OP_MFHI, 8, 0, 0, 0, 0, 0, 0));
    queue_instr(mk(OP_MULT, 2, 3, 0, 0, 0, 0, 0));
    queue_instr(mk(OP_MFHI, 9, 0, 0, 0, 0, 0, 0));
    queue_instr(mk(OP_MULTU, 3, 0, 0, 1, 32'hffff_ffff, 0, 0));
    queue_instr(mk(OP_MFLO, 10, 0, 0, 0, 0, 0, 0));
    queue_instr(mk(OP_ADDIU, 11, 1, 3, 0, 32'd5, 0, 0));
    queue_instr(mk(OP_NEGU, 12, 2, 0, 0, 0, 0, 0));
    queue_instr(mk(OP_SW, 2, 0, 0, 0, 32'd65534, 1, 0));
    queue_instr(mk(OP_LW, 13, 29, 0, 0, 32'hffff_fffe, 0, 0));
    queue_instr(mk(OP_LB, 14, 0, 0, 0, 32'd65535, 1, 0));
    queue_instr(mk(OP_SH, 3, 0, 0, 0, 32'd7, 1, 0));
    queue_instr(mk(OP_LH, 15, 0, 0, 0, 32'd7, 1, 0));
    queue_instr(mk(OP_LI, 0, 0, 0, 1, 32'd5, 0, 0));
    queue_instr(mk(OP_JALR, 3, 0, 0, 0, 0, 0, 0));
    queue_instr(mk(OP_BEQ, 5, 2, 0, 0, 0, 0, 16'hffff));
    queue_instr(mk(OP_SYSCALL, 0, 0, 0, 0, 0, 0, 0));
    queue_instr(mk(op_t'(0), 0, 0, 0, 0, 0, 0, 0));
    pending_instrs[$].func = 6'd63;
    for (int i = 0; i < 600; i++) queue_instr(random_instr());
    wait_drained();

    write_entry(16'h0000);
    set_idling(52, 26);
    for (int i = 0; i < 650; i++) queue_instr(random_instr());
    wait_drained();

    write_entry(16'($urandom));
    set_idling(0, 0);
    for (int i = 0; i < 350; i++) queue_instr(random_instr());
    // The sender pauses here until every prediction has been matched.
    wait_drained();
    for (int i = 0; i < 350; i++) queue_instr(random_instr());
    wait_drained();

    repeat (100) @(posedge clk);
    if (errors == 0 && expected_outcomes.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// File: sim.f
+incdir+hw/rtl
hw/rtl/mie_pkg.sv
hw/rtl/mie_div.sv
hw/rtl/mie_dp.sv
hw/rtl/mie_ctrl.sv
hw/rtl/mips_instruction_execute_top.sv
tb/testbench.sv
